// ===== rtl/vpp_pkg.sv =====
`timescale 1ns / 1ps
package vpp_pkg;

  typedef enum logic [1:0] {
    MODE_DATA     = 2'd0,
    MODE_HDR_ONLY = 2'd1,
    MODE_ABORT    = 2'd2
  } mode_e;

  // index of the last beat of a queued entry (0..2)
  typedef logic [1:0] beat_t;

  typedef struct packed {
    beat_t       last_idx;
    logic [7:0]  hdr2;
    logic [7:0]  data;
    logic        pend;
    logic        fend;
    logic [31:0] sum;
    logic        ok;
  } cmd_t;

  localparam logic [9:0] LIMIT_RESET = 10'd1022;

  localparam logic [7:0] HDR_LEN = 8'h02;
  localparam logic [7:0] HDR_FID = 8'h01;
  localparam logic [7:0] HDR_EOF = 8'h02;
  localparam logic [7:0] HDR_EOH = 8'h80;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;
  localparam int unsigned QCW    = 2;

endpackage

// ===== rtl/vpp_front.sv =====
`timescale 1ns / 1ps
module vpp_front #(
  parameter int unsigned MAX_PACKET_BYTES  = 1024,
  parameter int unsigned FRAME_LENGTH_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           data_byte_i,
  input  logic [23:0]          frame_bytes_i,
  input  logic                 cfg_we_i,
  input  logic [9:0]           cfg_wdata_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output vpp_pkg::cmd_t        cmd_o
);

  localparam int unsigned FLB    = FRAME_LENGTH_BITS;
  localparam int unsigned PW     = $clog2(MAX_PACKET_BYTES - 1);
  localparam int unsigned LIMMAX = MAX_PACKET_BYTES - 2;

  logic [9:0]     lim_q;
  logic [FLB-1:0] len_q, len_d;
  logic [FLB-1:0] rem_q, rem_d;
  logic           fid_q, fid_d;
  logic [PW-1:0]  pleft_q, pleft_d;
  logic           final_q, final_d;
  logic [31:0]    sum_q, sum_d;
  logic           smk_q, smk_d;
  logic [15:0]    tail_q, tail_d;
  logic [1:0]     off_q, off_d;

  vpp_pkg::mode_e mode;
  logic           accept;
  logic [31:0]    fb_ext;
  logic [FLB-1:0] fl;
  logic           loaded;
  logic [FLB-1:0] cur_len, cur_rem;
  logic           cur_fid;
  logic [31:0]    lim32, rem32, plen32;
  logic           new_pkt;
  logic [PW-1:0]  pl_cur;
  logic           fin_cur;
  logic           pend, fend, ok;
  logic [31:0]    sum_nxt;
  logic           smk_nxt;
  logic [15:0]    tail_nxt;

  assign mode       = vpp_pkg::mode_e'(mode_i);
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign fb_ext  = {8'd0, frame_bytes_i};
  assign fl      = fb_ext[FLB-1:0];
  assign loaded  = (len_q != '0);
  assign cur_len = loaded ? len_q : fl;
  assign cur_rem = loaded ? rem_q : fl;
  assign cur_fid = loaded ? fid_q : ~fid_q;

  always_comb begin
    if (lim_q == 10'd0) begin
      lim32 = 32'd1;
    end else if (32'(lim_q) > 32'(LIMMAX)) begin
      lim32 = 32'(LIMMAX);
    end else begin
      lim32 = 32'(lim_q);
    end
  end

  assign rem32   = 32'(cur_rem);
  assign plen32  = (rem32 < lim32) ? rem32 : lim32;
  assign new_pkt = (pleft_q == '0);
  assign pl_cur  = new_pkt ? plen32[PW-1:0] : pleft_q;
  assign fin_cur = new_pkt ? (plen32 == rem32) : final_q;
  assign pend    = (pl_cur == PW'(1));
  assign fend    = pend && fin_cur;

  assign sum_nxt  = sum_q + 32'(data_byte_i);
  assign tail_nxt = {tail_q[7:0], data_byte_i};

  always_comb begin
    case (off_q)
      2'd0:    smk_nxt = (data_byte_i == vpp_pkg::MARK_FF);
      2'd1:    smk_nxt = smk_q && (data_byte_i == vpp_pkg::MARK_SOI);
      default: smk_nxt = smk_q;
    endcase
  end

  assign ok = (32'(cur_len) >= 32'd4) && smk_nxt &&
              (tail_nxt == {vpp_pkg::MARK_FF, vpp_pkg::MARK_EOI});

  always_comb begin
    len_d   = len_q;
    rem_d   = rem_q;
    fid_d   = fid_q;
    pleft_d = pleft_q;
    final_d = final_q;
    sum_d   = sum_q;
    smk_d   = smk_q;
    tail_d  = tail_q;
    off_d   = off_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (accept) begin
      case (mode)
        vpp_pkg::MODE_DATA: begin
          if (loaded || (fl != '0)) begin
            push_o         = 1'b1;
            cmd_o.last_idx = new_pkt ? 2'd2 : 2'd0;
            cmd_o.hdr2     = vpp_pkg::HDR_EOH |
                             (cur_fid ? vpp_pkg::HDR_FID : 8'h00) |
                             (fin_cur ? vpp_pkg::HDR_EOF : 8'h00);
            cmd_o.data     = data_byte_i;
            cmd_o.pend     = pend;
            cmd_o.fend     = fend;
            cmd_o.sum      = fend ? sum_nxt : 32'd0;
            cmd_o.ok       = fend && ok;
            fid_d          = cur_fid;
            if (fend) begin
              len_d   = '0;
              rem_d   = '0;
              pleft_d = '0;
              final_d = 1'b0;
              sum_d   = '0;
              smk_d   = 1'b0;
              tail_d  = '0;
              off_d   = '0;
            end else begin
              len_d   = cur_len;
              rem_d   = cur_rem - FLB'(1);
              pleft_d = pl_cur - PW'(1);
              final_d = fin_cur;
              sum_d   = sum_nxt;
              smk_d   = smk_nxt;
              tail_d  = tail_nxt;
              off_d   = (off_q == 2'd2) ? off_q : off_q + 2'd1;
            end
          end
        end
        vpp_pkg::MODE_HDR_ONLY: begin
          if (new_pkt) begin
            push_o         = 1'b1;
            cmd_o.last_idx = 2'd1;
            cmd_o.pend     = 1'b1;
          end
        end
        vpp_pkg::MODE_ABORT: begin
          len_d   = '0;
          rem_d   = '0;
          pleft_d = '0;
          final_d = 1'b0;
          sum_d   = '0;
          smk_d   = 1'b0;
          tail_d  = '0;
          off_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q   <= vpp_pkg::LIMIT_RESET;
      len_q   <= '0;
      rem_q   <= '0;
      fid_q   <= 1'b0;
      pleft_q <= '0;
      final_q <= 1'b0;
      sum_q   <= '0;
      smk_q   <= 1'b0;
      tail_q  <= '0;
      off_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      len_q   <= len_d;
      rem_q   <= rem_d;
      fid_q   <= fid_d;
      pleft_q <= pleft_d;
      final_q <= final_d;
      sum_q   <= sum_d;
      smk_q   <= smk_d;
      tail_q  <= tail_d;
      off_q   <= off_d;
    end
  end

endmodule

// ===== rtl/vpp_fifo.sv =====
`timescale 1ns / 1ps
module vpp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vpp_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output vpp_pkg::cmd_t rdata_o
);

  vpp_pkg::cmd_t mem_q [vpp_pkg::QDEPTH];

  logic [vpp_pkg::QAW-1:0] wr_q, rd_q;
  logic [vpp_pkg::QCW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == vpp_pkg::QCW'(vpp_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + vpp_pkg::QCW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - vpp_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + vpp_pkg::QAW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + vpp_pkg::QAW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/vpp_back.sv =====
`timescale 1ns / 1ps
module vpp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  vpp_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          packet_end_o,
  output logic          frame_end_o,
  output logic [31:0]   frame_sum_o,
  output logic          markers_ok_o,
  output logic          run_last_o
);

  logic          ovalid_q, ovalid_d;
  vpp_pkg::beat_t beat_q, beat_d;
  logic          load, is_last;
  logic [7:0]    byte_q, byte_d;
  logic          pend_q, fend_q, ok_q, last_q;
  logic [31:0]   sum_q;

  assign load    = head_valid_i && (!ovalid_q || !out_stall_i);
  assign is_last = (beat_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    if (is_last) begin
      byte_d = head_i.data;
    end else if (beat_q == 2'd0) begin
      byte_d = vpp_pkg::HDR_LEN;
    end else begin
      byte_d = head_i.hdr2;
    end
  end

  always_comb begin
    beat_d   = beat_q;
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
      beat_d   = is_last ? 2'd0 : beat_q + 2'd1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      beat_q   <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      beat_q   <= beat_d;
    end
  end

  // header beats carry no flags; the entry's flags ride on its last beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      pend_q <= is_last && head_i.pend;
      fend_q <= is_last && head_i.fend;
      sum_q  <= is_last ? head_i.sum : 32'd0;
      ok_q   <= is_last && head_i.ok;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = byte_q;
  assign packet_end_o = pend_q;
  assign frame_end_o  = fend_q;
  assign frame_sum_o  = sum_q;
  assign markers_ok_o = ok_q;
  assign run_last_o   = last_q;

endmodule

// ===== rtl/video_payload_packetizer.sv =====
`timescale 1ns / 1ps
// An accepted item is written into the queue, and its first beat then goes to the output register.
// Throughput: one output beat per cycle while out_stall_i is low; a data byte gives 1 beat,
// or 3 when it opens a packet, and a header-only packet gives 2.
// The input takes one item per cycle while the two-entry queue to the beat unit has room.
// Reset (rst_ni low, asynchronous): no frame loaded, frame ID 0, queue and output empty,
// payload limit 1022.
module video_payload_packetizer #(
  parameter int unsigned MAX_PACKET_BYTES  = 1024,
  parameter int unsigned FRAME_LENGTH_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [23:0] frame_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_end_o,
  output logic        frame_end_o,
  output logic [31:0] frame_sum_o,
  output logic        markers_ok_o,
  output logic        run_last_o
);

  logic          q_full, q_valid, push, pop;
  vpp_pkg::cmd_t push_cmd, head_cmd;

  vpp_front #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .FRAME_LENGTH_BITS(FRAME_LENGTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .frame_bytes_i(frame_bytes_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  vpp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(head_cmd)
  );

  vpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .packet_end_o(packet_end_o),
    .frame_end_o (frame_end_o),
    .frame_sum_o (frame_sum_o),
    .markers_ok_o(markers_ok_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== rtl/vpp_checker.sv =====
`timescale 1ns / 1ps
module vpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_i,
  input logic        packet_end_i,
  input logic        frame_end_i,
  input logic [31:0] frame_sum_i,
  input logic        markers_ok_i,
  input logic        run_last_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(run_last_i))
    else $error("output beat changed while stalled");

  a_fend_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> packet_end_i)
    else $error("frame end without packet end");

  a_pend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_end_i |-> run_last_i)
    else $error("packet end not on last beat of its item");

  a_sum_only_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_end_i |-> (frame_sum_i == 32'd0) && !markers_ok_i)
    else $error("frame report outside frame end");

endmodule

bind video_payload_packetizer vpp_checker u_vpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_i  (out_byte_o),
  .packet_end_i(packet_end_o),
  .frame_end_i (frame_end_o),
  .frame_sum_i (frame_sum_o),
  .markers_ok_i(markers_ok_o),
  .run_last_i  (run_last_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import vpp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // packet of 1024 bytes minus the two header bytes
  localparam logic [9:0] PAYLOAD_MAX = 10'd1022;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 15;
  localparam int N_LIMITS = 7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [9:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  data_byte_i;
  logic [23:0] frame_bytes_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        packet_end_o;
  logic        frame_end_o;
  logic [31:0] frame_sum_o;
  logic        markers_ok_o;
  logic        run_last_o;

  video_payload_packetizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .frame_bytes_i (frame_bytes_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .packet_end_o  (packet_end_o),
    .frame_end_o   (frame_end_o),
    .frame_sum_o   (frame_sum_o),
    .markers_ok_o  (markers_ok_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  typedef struct packed {
    logic [7:0]  octet;
    logic        pkt_end;
    logic        frm_end;
    logic [31:0] fsum;
    logic        mk_ok;
    logic        last;
  } pkt_beat_t;

  // one stimulus row; when typed is set, the beats are spelled out here:
  // o0..o2 in order, flags on the last beat only
  typedef struct packed {
    logic [1:0]  m;
    logic [7:0]  d;
    logic [23:0] fb;
    logic        typed;
    logic [1:0]  n;
    logic [7:0]  o0, o1, o2;
    logic        pe, fe;
    logic [31:0] fsum;
    logic        ok;
  } dir_row_t;

  localparam int DIR_N = 23;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // mode         data   frame_bytes  typed n     beats                  pe    fe    sum       ok
    '{MODE_UNUSED,   8'hA5, 24'h000001, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'h5A, 24'h000000, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_HDR_ONLY, 8'h00, 24'h000000, 1'b1, 2'd2, 8'h02, 8'h00, 8'h00, 1'b1, 1'b0, 32'h0,   1'b0},
    '{MODE_ABORT,    8'hFF, 24'hFFFFFF, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hFF, 24'h000004, 1'b1, 2'd3, 8'h02, 8'h83, 8'hFF, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hD8, 24'hFFFFFF, 1'b1, 2'd1, 8'hD8, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_HDR_ONLY, 8'h00, 24'h000000, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hFF, 24'h000000, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hD9, 24'h123456, 1'b1, 2'd1, 8'hD9, 8'h00, 8'h00, 1'b1, 1'b1, 32'h3AF, 1'b1},
    '{MODE_DATA,     8'h00, 24'h000001, 1'b1, 2'd3, 8'h02, 8'h82, 8'h00, 1'b1, 1'b1, 32'h0,   1'b0},
    '{MODE_HDR_ONLY, 8'hFF, 24'hFFFFFF, 1'b1, 2'd2, 8'h02, 8'h00, 8'h00, 1'b1, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hFF, 24'h000003, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hD8, 24'h000000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hD9, 24'h000003, 1'b1, 2'd1, 8'hD9, 8'h00, 8'h00, 1'b1, 1'b1, 32'h2B0, 1'b0},
    '{MODE_DATA,     8'h00, 24'hFFFFFF, 1'b1, 2'd3, 8'h02, 8'h80, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hFF, 24'h000000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_ABORT,    8'h00, 24'h000000, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'h7F, 24'h000002, 1'b1, 2'd3, 8'h02, 8'h83, 8'h7F, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'h80, 24'h000000, 1'b1, 2'd1, 8'h80, 8'h00, 8'h00, 1'b1, 1'b1, 32'hFF,  1'b0},
    '{MODE_DATA,     8'hFF, 24'h000004, 1'b1, 2'd3, 8'h02, 8'h82, 8'hFF, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hD8, 24'h000000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'h00, 24'h000000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0,   1'b0},
    '{MODE_DATA,     8'hD9, 24'h000000, 1'b1, 2'd1, 8'hD9, 8'h00, 8'h00, 1'b1, 1'b1, 32'h2B0, 1'b0}
  };

  // packetizer state as the predictor sees it
  logic [9:0]  lim_reg;
  logic [23:0] f_off;
  logic [23:0] f_len;
  logic        fid;
  logic [9:0]  pkt_left;
  logic        pkt_final;
  logic [31:0] sum32;
  logic        soi_ok;
  logic [15:0] tail16;

  pkt_beat_t pred_beats [3];
  int        pred_n;
  pkt_beat_t beats_due [$];

  int  errors = 0;
  int  items_sent = 0;
  int  beats_checked = 0;
  int  frames_done = 0;
  int  holds_asked = 0;
  int  holds_done = 0;
  bit  quiet = 1'b0;

  function automatic void clear_frame();
    f_off = '0;
    f_len = '0;
    pkt_left = '0;
    pkt_final = 1'b0;
    sum32 = '0;
    soi_ok = 1'b0;
    tail16 = '0;
  endfunction

  function automatic void add_beat(logic [7:0] o, logic pe, logic fe, logic [31:0] s,
                                   logic ok);
    pred_beats[pred_n] = '{o, pe, fe, s, ok, 1'b0};
    pred_n++;
  endfunction

  function automatic void packetize(logic [1:0] m, logic [7:0] b, logic [23:0] fb);
    logic [9:0]  lim;
    logic [23:0] rem;
    logic [23:0] len;
    logic        pe;
    logic        fe;
    pred_n = 0;
    case (m)
      MODE_HDR_ONLY: begin
        if (pkt_left != 0) return;
        add_beat(HDR_LEN, 1'b0, 1'b0, '0, 1'b0);
        add_beat(8'h00, 1'b1, 1'b0, '0, 1'b0);
      end
      MODE_ABORT: begin
        clear_frame();
        return;
      end
      MODE_DATA: begin
        if (f_len == 0) begin
          if (fb == 0) return;
          clear_frame();
          f_len = fb;
          fid = ~fid;
        end
        if (pkt_left == 0) begin
          lim = (lim_reg == 0) ? 10'd1 : (lim_reg > PAYLOAD_MAX) ? PAYLOAD_MAX : lim_reg;
          rem = f_len - f_off;
          len = (rem < 24'(lim)) ? rem : 24'(lim);
          pkt_left = len[9:0];
          pkt_final = (len == rem);
          add_beat(HDR_LEN, 1'b0, 1'b0, '0, 1'b0);
          add_beat(HDR_EOH | (fid ? HDR_FID : 8'h00) | (pkt_final ? HDR_EOF : 8'h00),
                   1'b0, 1'b0, '0, 1'b0);
        end
        sum32 = sum32 + 32'(b);
        if (f_off == 0) soi_ok = (b == MARK_FF);
        else if (f_off == 1) soi_ok = soi_ok && (b == MARK_SOI);
        tail16 = {tail16[7:0], b};
        f_off = f_off + 1'b1;
        pkt_left = pkt_left - 1'b1;
        pe = (pkt_left == 0);
        fe = pe && pkt_final;
        if (fe) begin
          add_beat(b, pe, fe, sum32,
                   (f_len >= 4) && soi_ok && (tail16 == {MARK_FF, MARK_EOI}));
          clear_frame();
        end else begin
          add_beat(b, pe, 1'b0, '0, 1'b0);
        end
      end
      default: return;
    endcase
    pred_beats[pred_n - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (errors <= 50)
        $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  function automatic void check_beat();
    pkt_beat_t e;
    beats_checked++;
    if (beats_due.size() == 0) begin
      errors++;
      if (errors <= 50)
        $display("%0t: beat %02h arrived with nothing expected", $time, out_byte_o);
      return;
    end
    e = beats_due.pop_front();
    check_field("out_byte", 32'(e.octet), 32'(out_byte_o));
    check_field("packet_end", 32'(e.pkt_end), 32'(packet_end_o));
    check_field("frame_end", 32'(e.frm_end), 32'(frame_end_o));
    check_field("frame_sum", e.fsum, frame_sum_o);
    check_field("markers_ok", 32'(e.mk_ok), 32'(markers_ok_o));
    check_field("run_last", 32'(e.last), 32'(run_last_o));
    if (e.frm_end) frames_done++;
  endfunction

  task automatic send_row(input dir_row_t r);
    int gap;
    pkt_beat_t bt;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= r.m;
    data_byte_i <= r.d;
    frame_bytes_i <= r.fb;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    packetize(r.m, r.d, r.fb);
    if (r.typed) begin
      for (int k = 0; k < r.n; k++) begin
        bt = '0;
        bt.octet = (k == 0) ? r.o0 : (k == 1) ? r.o1 : r.o2;
        if (k == r.n - 1) begin
          bt.pkt_end = r.pe;
          bt.frm_end = r.fe;
          bt.fsum = r.fsum;
          bt.mk_ok = r.ok;
          bt.last = 1'b1;
        end
        beats_due.push_back(bt);
      end
    end else begin
      for (int k = 0; k < pred_n; k++) beats_due.push_back(pred_beats[k]);
    end
  endtask

  task automatic send_item(input logic [1:0] m, input logic [7:0] d, input logic [23:0] fb);
    dir_row_t r;
    r = '0;
    r.m = m;
    r.d = d;
    r.fb = fb;
    send_row(r);
  endtask

  // nsend < flen leaves the frame unfinished and aborts it
  task automatic send_frame(input int flen, input int nsend, input bit marked);
    logic [7:0] b;
    for (int i = 0; i < nsend; i++) begin
      b = 8'($urandom);
      if (marked) begin
        if (i == 0 || i == flen - 2) b = MARK_FF;
        else if (i == 1) b = MARK_SOI;
        else if (i == flen - 1) b = MARK_EOI;
      end
      if (i > 0 && $urandom_range(0, 19) == 0)
        send_item(MODE_HDR_ONLY, 8'($urandom), 24'($urandom));
      send_item(MODE_DATA, b, (i == 0) ? 24'(flen) : 24'($urandom));
    end
    if (nsend < flen) send_item(MODE_ABORT, 8'($urandom), 24'($urandom));
  endtask

  task automatic random_burst(inout int budget);
    int r;
    int flen;
    int nsend;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_item(MODE_HDR_ONLY, 8'($urandom), 24'($urandom));
      budget--;
    end else if (r < 10) begin
      case ($urandom_range(0, 2))
        0: send_item(MODE_UNUSED, 8'($urandom), 24'($urandom));
        1: send_item(MODE_ABORT, 8'($urandom), 24'($urandom));
        default: send_item(MODE_DATA, 8'($urandom), 24'h0);
      endcase
    end else if (r < 20) begin
      flen = ($urandom_range(0, 3) == 0) ? int'({1'b1, 23'($urandom)})
                                          : $urandom_range(2, 40);
      nsend = $urandom_range(1, (flen > 13) ? 12 : flen - 1);
      send_frame(flen, nsend, $urandom_range(0, 1) == 1);
      budget -= nsend;
    end else begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 70) : $urandom_range(1, 20);
      send_frame(flen, flen, flen >= 4 && $urandom_range(0, 1) == 1);
      budget -= flen;
    end
  endtask

  // register writes only once every expected beat is out
  task automatic write_limit(input logic [9:0] v);
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_reg = v;
  endtask

  initial begin : beat_sink
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        check_beat();
        stall_left = quiet ? 0 : $urandom_range(0, 11);
      end
      // long hold-off so the internal queue fills and the input stalls
      if (holds_done < holds_asked) begin
        stall_left += HOLD_CYCLES;
        holds_done++;
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin : stimulus
    logic [9:0] limits [N_LIMITS];
    int budget;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    mode_i <= MODE_DATA;
    data_byte_i <= '0;
    frame_bytes_i <= '0;
    lim_reg = LIMIT_RESET;
    fid = 1'b0;
    clear_frame();
    limits = '{10'd0, 10'd1023, 10'd1, 10'd2, 10'd3, 10'd0, 10'd0};
    limits[5] = 10'($urandom_range(4, 9));
    limits[6] = 10'($urandom_range(1, 1023));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) send_row(DIR_ROWS[i]);

    for (int p = 0; p < N_LIMITS; p++) begin
      write_limit(limits[p]);
      quiet = (p == 2 || p == 4);
      if (quiet) holds_asked++;
      // frame one byte over the clamped limit: its first header shows no end-of-frame bit
      if (limits[p] == 10'd1023) send_frame(1023, 1, 1'b1);
      budget = PHASE_ITEMS;
      while (budget > 0) random_burst(budget);
    end

    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run: %0d input items over %0d payload limits, %0d beats checked,",
             items_sent, N_LIMITS + 1, beats_checked);
    $display("     %0d frames closed; header-only packets, aborts, empty frames, markers,",
             frames_done);
    $display("     limit clamping and long output hold-offs.");
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
